>>> hdl/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define DEQ_ASSERT_SAME(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("deque check failed");

// Check that cond implies prop in the following cycle.
`define DEQ_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("deque check failed");

`endif

>>> hdl/deq_pkg.sv
// Types, constants and ring helpers for the double-ended queue.
package deq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int WORD_W     = 32;
	localparam int CMD_W      = 3;
	localparam int POS_W      = 4;
	localparam int STAT_W     = 2;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] elem_t;
	typedef logic [WORD_W-1:0]     word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE       = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4,
		CMD_READ       = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD
	} state_t;

	// Ring index of the entry off places behind head (off below CAPACITY).
	function automatic addr_t ring_add(input addr_t head, input cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(CAPACITY)) begin
			sum = sum - (CNT_W + 1)'(CAPACITY);
		end
		return ADDR_W'(sum);
	endfunction

	// Ring index one place in front of head.
	function automatic addr_t ring_dec(input addr_t head);
		addr_t res;
		if (head == '0) begin
			res = ADDR_W'(CAPACITY - 1);
		end else begin
			res = head - addr_t'(1);
		end
		return res;
	endfunction

endpackage

>>> hdl/deq_cmd_if.sv
// Command channel: one command word with its element and position.
interface deq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [deq_pkg::CMD_W-1:0]   command;
	logic [deq_pkg::WORD_W-1:0]  value;
	logic [deq_pkg::POS_W-1:0]   position;

	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

>>> hdl/deq_res_if.sv
// Result channel: one result word per command.
interface deq_res_if;
	logic                        valid;
	logic                        ready;
	logic [deq_pkg::WORD_W-1:0]  data;
	logic [deq_pkg::WORD_W-1:0]  front_value;
	logic [deq_pkg::WORD_W-1:0]  back_value;
	logic [deq_pkg::CNT_W-1:0]   occupancy;
	logic                        is_empty;
	logic                        is_full;
	logic [deq_pkg::STAT_W-1:0]  status;

	modport source (output valid, data, front_value, back_value, occupancy, is_empty,
		is_full, status, input ready);
	modport sink   (input valid, data, front_value, back_value, occupancy, is_empty,
		is_full, status, output ready);
endinterface

>>> hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; hold data while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/double_ended_queue.sv
// Bounded double-ended queue on a ring store held in two mirrored RAMs.
// A command word is taken only in IDLE; FETCH and LOAD follow before the next.
// IDLE reads the popped or read element, FETCH latches it and reads the front and
// back elements, and LOAD fills the output register once it is free.
// Reset clears head, count, sequencer and output valid; RAM contents stay
// undefined until written, and no clearing pass runs.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
	input logic       clk,
	input logic       arst_n,
	deq_cmd_if.sink   cmd,
	deq_res_if.source res
);

	deq_pkg::state_t  state_q, state_nxt;
	deq_pkg::addr_t   head_q, head_nxt;
	deq_pkg::cnt_t    count_q, count_nxt;
	deq_pkg::status_t status_q, status_nxt;
	logic             take_data_q, take_data_nxt;
	deq_pkg::elem_t   data_q;

	logic             accept;
	logic             load_out;
	logic             out_valid_q;

	logic             ram_we;
	deq_pkg::addr_t   ram_waddr;
	deq_pkg::elem_t   ram_wdata;
	logic             re0, re1;
	deq_pkg::addr_t   raddr0, raddr1, step_raddr;
	deq_pkg::elem_t   rdata0, rdata1;

	logic [deq_pkg::CMP_W-1:0] pos_ext, cnt_ext;
	logic             is_full_now, is_empty_now;

	assign accept = cmd.valid && cmd.ready;

	// Decode the command against the current head and count
	always_comb begin
		head_nxt      = head_q;
		count_nxt     = count_q;
		status_nxt    = deq_pkg::STAT_OK;
		take_data_nxt = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = head_q;
		step_raddr    = head_q;
		pos_ext       = deq_pkg::CMP_W'(cmd.position);
		cnt_ext       = deq_pkg::CMP_W'(count_q);
		is_full_now   = (count_q == deq_pkg::cnt_t'(deq_pkg::CAPACITY));
		is_empty_now  = (count_q == '0);
		case (cmd.command)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (is_full_now) begin
					status_nxt = deq_pkg::STAT_FULL;
				end else begin
					head_nxt  = deq_pkg::ring_dec(head_q);
					ram_we    = accept;
					ram_waddr = deq_pkg::ring_dec(head_q);
					count_nxt = count_q + deq_pkg::cnt_t'(1);
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (is_full_now) begin
					status_nxt = deq_pkg::STAT_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = deq_pkg::ring_add(head_q, count_q);
					count_nxt = count_q + deq_pkg::cnt_t'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (is_empty_now) begin
					status_nxt = deq_pkg::STAT_EMPTY;
				end else begin
					take_data_nxt = 1'b1;
					step_raddr    = head_q;
					head_nxt      = deq_pkg::ring_add(head_q, deq_pkg::cnt_t'(1));
					count_nxt     = count_q - deq_pkg::cnt_t'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (is_empty_now) begin
					status_nxt = deq_pkg::STAT_EMPTY;
				end else begin
					take_data_nxt = 1'b1;
					step_raddr    = deq_pkg::ring_add(head_q, count_q - deq_pkg::cnt_t'(1));
					count_nxt     = count_q - deq_pkg::cnt_t'(1);
				end
			end
			deq_pkg::CMD_READ: begin
				if (is_empty_now) begin
					status_nxt = deq_pkg::STAT_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_nxt = deq_pkg::STAT_RANGE;
				end else begin
					take_data_nxt = 1'b1;
					step_raddr    = deq_pkg::ring_add(head_q,
						deq_pkg::cnt_t'(pos_ext));
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata = deq_pkg::DATA_WIDTH'(cmd.value);

	// Sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			deq_pkg::ST_IDLE:  if (accept) state_nxt = deq_pkg::ST_FETCH;
			deq_pkg::ST_FETCH: state_nxt = deq_pkg::ST_LOAD;
			deq_pkg::ST_LOAD:  if (!out_valid_q || res.ready) state_nxt = deq_pkg::ST_IDLE;
			default:           state_nxt = deq_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, RAM reads, output load
	always_comb begin
		cmd.ready = 1'b0;
		re0       = 1'b0;
		re1       = 1'b0;
		raddr0    = head_q;
		raddr1    = step_raddr;
		load_out  = 1'b0;
		case (state_q)
			deq_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				re1       = cmd.valid;
			end
			deq_pkg::ST_FETCH: begin
				re0    = 1'b1;
				re1    = 1'b1;
				raddr1 = deq_pkg::ring_add(head_q, count_q - deq_pkg::cnt_t'(1));
			end
			deq_pkg::ST_LOAD: begin
				load_out = !out_valid_q || res.ready;
			end
			default: begin
			end
		endcase
	end

	// Advance sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// Hold per-command status and the fetched element
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			take_data_q <= take_data_nxt;
		end
		if (state_q == deq_pkg::ST_FETCH) begin
			data_q <= take_data_q ? rdata1 : '0;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			res.data        <= deq_pkg::WORD_W'(data_q);
			res.front_value <= (count_q != '0) ? deq_pkg::WORD_W'(rdata0) : '0;
			res.back_value  <= (count_q != '0) ? deq_pkg::WORD_W'(rdata1) : '0;
			res.occupancy   <= count_q;
			res.is_empty    <= (count_q == '0);
			res.is_full     <= (count_q == deq_pkg::cnt_t'(deq_pkg::CAPACITY));
			res.status      <= status_q;
		end
	end

	assign res.valid = out_valid_q;

	// Mirrored ring store: copy 0 serves the front, copy 1 the step and the back
	deq_ram #(.WIDTH(deq_pkg::DATA_WIDTH), .DEPTH(deq_pkg::CAPACITY)) u_ram0 (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (re0),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	deq_ram #(.WIDTH(deq_pkg::DATA_WIDTH), .DEPTH(deq_pkg::CAPACITY)) u_ram1 (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (re1),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	`DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= deq_pkg::cnt_t'(deq_pkg::CAPACITY))
	`DEQ_ASSERT_NEXT(a_accept_fetch, accept, state_q == deq_pkg::ST_FETCH)
	`DEQ_ASSERT_SAME(a_empty_flag, res.valid, res.is_empty == (res.occupancy == '0))
	`DEQ_ASSERT_SAME(a_no_write_busy, ram_we, state_q == deq_pkg::ST_IDLE)

endmodule

>>> bench/double_ended_queue_monitor.sv
// Monitor for the double-ended queue: mirrors the ring store and checks each result word.
`timescale 1ns / 100ps

module double_ended_queue_monitor
	import deq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	deq_cmd_if    cmd,
	deq_res_if    res,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		word_t   data;
		word_t   front_value;
		word_t   back_value;
		cnt_t    occupancy;
		logic    is_empty;
		logic    is_full;
		status_t status;
	} deque_outcome_t;

	// Mirror of the block's ring store, head and element count
	elem_t ring_mem [CAPACITY];
	addr_t head_idx;
	cnt_t  elem_cnt;

	deque_outcome_t deque_outcomes [$];

	// Ring index of the entry off places behind the head
	function automatic addr_t slot_at(input int off);
		return addr_t'((int'(head_idx) + off) % CAPACITY);
	endfunction

	// Apply one command to the mirror and return the word it should produce
	function automatic deque_outcome_t deque_step(input logic [CMD_W-1:0] op, input word_t v,
		input logic [POS_W-1:0] pos);
		deque_outcome_t o;
		elem_t          got;
		got = '0;
		o.status = STAT_OK;
		case (op)
			CMD_PUSH_FRONT: begin
				if (elem_cnt >= cnt_t'(CAPACITY)) begin
					o.status = STAT_FULL;
				end else begin
					head_idx = slot_at(CAPACITY - 1);
					ring_mem[head_idx] = elem_t'(v);
					elem_cnt = elem_cnt + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (elem_cnt >= cnt_t'(CAPACITY)) begin
					o.status = STAT_FULL;
				end else begin
					ring_mem[slot_at(int'(elem_cnt))] = elem_t'(v);
					elem_cnt = elem_cnt + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (elem_cnt == '0) begin
					o.status = STAT_EMPTY;
				end else begin
					got = ring_mem[head_idx];
					head_idx = slot_at(1);
					elem_cnt = elem_cnt - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (elem_cnt == '0) begin
					o.status = STAT_EMPTY;
				end else begin
					got = ring_mem[slot_at(int'(elem_cnt) - 1)];
					elem_cnt = elem_cnt - 1'b1;
				end
			end
			CMD_READ: begin
				if (elem_cnt == '0) begin
					o.status = STAT_EMPTY;
				end else if (cnt_t'(pos) >= elem_cnt) begin
					o.status = STAT_RANGE;
				end else begin
					got = ring_mem[slot_at(int'(pos))];
				end
			end
			default: begin
				// no operation, spare codes included
			end
		endcase
		o.data        = word_t'(got);
		o.front_value = (elem_cnt != '0) ? word_t'(ring_mem[head_idx]) : '0;
		o.back_value  = (elem_cnt != '0) ? word_t'(ring_mem[slot_at(int'(elem_cnt) - 1)]) : '0;
		o.occupancy   = elem_cnt;
		o.is_empty    = (elem_cnt == '0);
		o.is_full     = (elem_cnt == cnt_t'(CAPACITY));
		return o;
	endfunction

	task automatic check_field(input string field, input word_t want, input word_t got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		deque_outcome_t want;
		if (!arst_n) begin
			head_idx = '0;
			elem_cnt = '0;
			deque_outcomes.delete();
			pending <= 0;
		end else begin
			// compare a delivered result word with the oldest prediction
			if (res.valid && res.ready) begin
				if (deque_outcomes.size() == 0) begin
					$error("result word arrived with no command outstanding");
					fail_count++;
				end else begin
					want = deque_outcomes.pop_front();
					check_field("data", want.data, res.data);
					check_field("front_value", want.front_value, res.front_value);
					check_field("back_value", want.back_value, res.back_value);
					check_field("occupancy", word_t'(want.occupancy), word_t'(res.occupancy));
					check_field("is_empty", word_t'(want.is_empty), word_t'(res.is_empty));
					check_field("is_full", word_t'(want.is_full), word_t'(res.is_full));
					check_field("status", word_t'(want.status), word_t'(res.status));
				end
			end
			// predict the result of an accepted command word
			if (cmd.valid && cmd.ready) begin
				deque_outcomes.push_back(deque_step(cmd.command, cmd.value, cmd.position));
			end
			pending <= deque_outcomes.size();
		end
	end

endmodule

>>> bench/double_ended_queue_test.sv
// Top of the double-ended queue bench: clock, reset, command and result traffic, verdict.
`timescale 1ns / 100ps

module double_ended_queue_test;
	import deq_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int RANDOM_WORDS  = 950;
	localparam int PHASE_COUNT   = 5;
	localparam int MODE_SPAN     = 32;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_CYCLES  = 20;

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   send_idle;
	int   recv_stall;
	logic hold_req;

	deq_cmd_if cmd_ch ();
	deq_res_if res_ch ();

	double_ended_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	double_ended_queue_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run if traffic stops moving
	initial begin
		#2000000;
		$display("double_ended_queue_test: FAIL");
		$finish;
	end

	// Drive result ready: random stalls, plus a long hold-off on request
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Offer one command word, idling at random first; return once it is taken
	task automatic send_word(input logic [CMD_W-1:0] op, input word_t v,
		input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= op;
		cmd_ch.value    <= v;
		cmd_ch.position <= pos;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic word_t pick_value();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	// Choose a command, leaning toward pushes or pops by mode
	function automatic logic [CMD_W-1:0] pick_command(input int mode);
		int r;
		int push_pct;
		int pop_pct;
		int read_pct;
		r = $urandom_range(99);
		case (mode)
			MODE_FILL: begin
				push_pct = 60;
				pop_pct  = 15;
				read_pct = 20;
			end
			MODE_DRAIN: begin
				push_pct = 15;
				pop_pct  = 60;
				read_pct = 20;
			end
			default: begin
				push_pct = 30;
				pop_pct  = 30;
				read_pct = 30;
			end
		endcase
		if (r < push_pct) begin
			return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		end else if (r < push_pct + pop_pct) begin
			return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
		end else if (r < push_pct + pop_pct + read_pct) begin
			return CMD_READ;
		end
		case ($urandom_range(2))
			0: return CMD_NONE;
			1: return CMD_SPARE_LO;
			default: return CMD_SPARE_HI;
		endcase
	endfunction

	initial begin
		int               mode;
		int               per_phase;
		logic [CMD_W-1:0] op;
		word_t            v;

		arst_n           <= 1'b0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.command   <= CMD_NONE;
		cmd_ch.value     <= '0;
		cmd_ch.position  <= '0;
		hold_req         <= 1'b0;
		send_idle        = 0;
		recv_stall       <= 0;
		per_phase        = RANDOM_WORDS / PHASE_COUNT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, out-of-range read, wrap, fill, push when full, spare codes
		send_word(CMD_NONE, '1, '1);
		send_word(CMD_POP_FRONT, '0, '0);
		send_word(CMD_POP_BACK, '0, '0);
		send_word(CMD_READ, '0, '0);
		send_word(CMD_PUSH_BACK, '0, '0);
		send_word(CMD_READ, '0, 4'd1);
		for (int i = 1; i < CAPACITY; i++) begin
			if (i == 1) begin
				v = '1;
			end else if (i == 2) begin
				v = 32'h8000_0000;
			end else begin
				v = $urandom;
			end
			send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, v, '0);
		end
		send_word(CMD_PUSH_FRONT, 32'h1234_5678, '0);
		send_word(CMD_PUSH_BACK, 32'h8765_4321, '0);
		send_word(CMD_READ, '0, '1);
		send_word(CMD_SPARE_LO, '1, '1);
		send_word(CMD_SPARE_HI, '0, '0);
		wait_drained();

		// Random: phases of sender idling and result stalls, each in spans that fill, drain or mix
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				1: begin
					send_idle = 57;
					recv_stall <= 0;
				end
				2: begin
					send_idle = 0;
					recv_stall <= 57;
				end
				3: begin
					send_idle = 25;
					recv_stall <= 25;
				end
				default: begin
					send_idle = 0;
					recv_stall <= 0;
				end
			endcase
			// hold results off for a long stretch while commands keep coming
			if (ph == 0) begin
				hold_req <= ~hold_req;
			end
			mode = MODE_MIXED;
			for (int n = 0; n < per_phase; n++) begin
				if (n % MODE_SPAN == 0) begin
					mode = $urandom_range(MODE_MIXED);
				end
				op = pick_command(mode);
				send_word(op, pick_value(), POS_W'($urandom_range(CAPACITY - 1)));
			end
			// pause the sender until every result is back
			if (ph == 1) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("double_ended_queue_test: PASS");
		end else begin
			$display("double_ended_queue_test: FAIL");
		end
		$finish;
	end

endmodule

>>> double_ended_queue.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_cmd_if.sv
hdl/deq_res_if.sv
hdl/deq_ram.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_monitor.sv
bench/double_ended_queue_test.sv
